// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the odometry RTL.
// Depends on nothing; users must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ODO_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ODO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ODO_ASSERT_IMP(lbl, ante, cons, msg)
`define ODO_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/odo_pkg.sv =====
// Types, constants and tables for the differential drive odometry core.
// Used by every module of the block; depends on nothing.
package odo_pkg;

    localparam logic [15:0] TRACK_WIDTH_RESET = 16'd141;
    localparam logic [15:0] INTERVAL_RESET    = 16'd50;

    localparam logic [0:0] CFG_TRACK_WIDTH = 1'b0;
    localparam logic [0:0] CFG_INTERVAL    = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    localparam int                 CORDIC_STEPS = 14;
    localparam logic signed [17:0] CORDIC_GAIN  = 18'sd19898;
    localparam logic [29:0]        INV_TWO_PI   = 30'd683565276;

    localparam int DIV_BITS  = 56;
    localparam int DIV_DEN   = 16;
    localparam int DIV_STEPS = 2;

    typedef enum logic [1:0] {
        KIND_HOLD,
        KIND_STRAIGHT,
        KIND_TURN
    } t_kind;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
    } t_in;

    typedef struct packed {
        logic signed [31:0] x_pos;
        logic signed [31:0] y_pos;
        logic [15:0]        heading;
        logic               pose_updated;
    } t_out;

    typedef struct packed {
        t_kind              kind;
        logic [31:0]        dt;
        logic signed [15:0] vl;
        logic signed [15:0] vr;
    } t_cmd;

    typedef struct packed {
        logic                  start;
        logic [DIV_BITS-1:0]   dividend;
        logic [DIV_DEN-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic        start;
        logic [15:0] angle;
    } t_cor_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TNUM,
        S_QGO,
        S_QWAIT,
        S_DH1,
        S_DH2,
        S_RWAIT,
        S_TMUL,
        S_TSUM,
        S_SMUL,
        S_SWAIT,
        S_SPROD,
        S_SSUM,
        S_DONE
    } t_state;

    function automatic logic signed [17:0] cordic_atan(input logic [3:0] idx);
        logic signed [17:0] v;
        case (idx)
            4'd0:    v = 18'sd8192;
            4'd1:    v = 18'sd4836;
            4'd2:    v = 18'sd2555;
            4'd3:    v = 18'sd1297;
            4'd4:    v = 18'sd651;
            4'd5:    v = 18'sd326;
            4'd6:    v = 18'sd163;
            4'd7:    v = 18'sd81;
            4'd8:    v = 18'sd41;
            4'd9:    v = 18'sd20;
            4'd10:   v = 18'sd10;
            4'd11:   v = 18'sd5;
            4'd12:   v = 18'sd3;
            4'd13:   v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/odo_front.sv =====
// Front end: takes input words, holds configuration and the last update time,
// and classifies each word into a hold, straight or turn command. Uses odo_pkg.
module odo_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  odo_pkg::t_in       i_in_data,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_q_full,
    output logic               o_push,
    output odo_pkg::t_cmd      o_cmd,
    output logic [15:0]        o_track
);

    logic [15:0] r_track;
    logic [15:0] r_interval;
    logic [31:0] r_last_ms;
    logic [31:0] dt;
    logic        upd;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign dt         = i_in_data.now_ms - r_last_ms;
    assign upd        = dt >= {16'd0, r_interval};
    assign o_track    = (r_track == 16'd0) ? 16'd1 : r_track;

    always_comb begin
        o_cmd.dt = dt;
        o_cmd.vl = i_in_data.left_speed;
        o_cmd.vr = i_in_data.right_speed;
        if (!upd) begin
            o_cmd.kind = odo_pkg::KIND_HOLD;
        end else if (i_in_data.left_speed == i_in_data.right_speed) begin
            o_cmd.kind = odo_pkg::KIND_STRAIGHT;
        end else begin
            o_cmd.kind = odo_pkg::KIND_TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track    <= odo_pkg::TRACK_WIDTH_RESET;
            r_interval <= odo_pkg::INTERVAL_RESET;
            r_last_ms  <= 32'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    odo_pkg::CFG_TRACK_WIDTH: r_track    <= i_cfg_data;
                    odo_pkg::CFG_INTERVAL:    r_interval <= i_cfg_data;
                endcase
            end
            if (o_push && upd) begin
                r_last_ms <= i_in_data.now_ms;
            end
        end
    end

endmodule

// ===== hw/rtl/odo_queue.sv =====
// Short command queue between the front end and the back end.
// Uses odo_pkg for the command type.
module odo_queue #(
    parameter int DEPTH = odo_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  odo_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output odo_pkg::t_cmd  o_head,
    output logic           o_empty,
    output logic           o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    odo_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          wr_en;
    logic          rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/odo_div.sv =====
// Iterative unsigned restoring divider, DIV_STEPS quotient bits per cycle.
// Uses odo_pkg for widths and the request struct.
module odo_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  odo_pkg::t_div_req             i_req,
    output logic                          o_busy,
    output logic [odo_pkg::DIV_BITS-1:0]  o_quo
);

    localparam int NB  = odo_pkg::DIV_BITS;
    localparam int DB  = odo_pkg::DIV_DEN;
    localparam int NS  = odo_pkg::DIV_STEPS;
    localparam int NC  = NB / NS;
    localparam int CNW = $clog2(NC);

    logic [NB-1:0]  r_quo;
    logic [DB-1:0]  r_rem;
    logic [DB-1:0]  r_den;
    logic [CNW-1:0] r_cnt;
    logic           r_busy;
    logic [NB-1:0]  n_quo;
    logic [DB-1:0]  n_rem;

    always_comb begin
        logic [DB:0] t;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < NS; k++) begin
            t     = {n_rem, n_quo[NB-1]};
            n_quo = {n_quo[NB-2:0], 1'b0};
            if (t >= {1'b0, r_den}) begin
                n_rem    = DB'(t - {1'b0, r_den});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = t[DB-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNW'(NC - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

// ===== hw/rtl/odo_cordic.sv =====
// Iterative CORDIC sine and cosine of a 16-bit binary angle, one step a cycle.
// Uses odo_pkg for the arctangent table and gain.
module odo_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  odo_pkg::t_cor_req  i_req,
    output logic               o_busy,
    output logic signed [15:0] o_sin,
    output logic signed [15:0] o_cos
);

    logic signed [17:0] r_x;
    logic signed [17:0] r_y;
    logic signed [17:0] r_z;
    logic               r_flip;
    logic [3:0]         r_i;
    logic               r_busy;
    logic [15:0]        a_in;
    logic [15:0]        a_fold;
    logic               flip_in;
    logic signed [17:0] xs;
    logic signed [17:0] ys;
    logic signed [17:0] xo;
    logic signed [17:0] yo;

    assign a_in    = i_req.angle + 16'd16384;
    assign flip_in = a_in[15];
    assign a_fold  = flip_in ? (i_req.angle ^ 16'h8000) : i_req.angle;
    assign xs      = r_x >>> r_i;
    assign ys      = r_y >>> r_i;
    assign xo      = r_flip ? -r_x : r_x;
    assign yo      = r_flip ? -r_y : r_y;

    function automatic logic signed [15:0] clamp15(input logic signed [17:0] v);
        logic signed [15:0] c;
        if (v > 18'sd32767) begin
            c = 16'sd32767;
        end else if (v < -18'sd32767) begin
            c = -16'sd32767;
        end else begin
            c = v[15:0];
        end
        return c;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x    <= odo_pkg::CORDIC_GAIN;
            r_y    <= 18'sd0;
            r_z    <= 18'($signed(a_fold));
            r_flip <= flip_in;
        end else if (r_busy) begin
            if (!r_z[17]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - odo_pkg::cordic_atan(r_i);
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + odo_pkg::cordic_atan(r_i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
        end else if (r_busy) begin
            r_i <= r_i + 1'b1;
            if (r_i == 4'(odo_pkg::CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_sin  = clamp15(yo);
    assign o_cos  = clamp15(xo);

endmodule

// ===== hw/rtl/odo_back.sv =====
// Back end: sequences the pose update of each command through the shared
// divider and CORDIC units and holds the pose and the output register. Uses odo_pkg.
`include "assert_macros.svh"
module odo_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  odo_pkg::t_cmd      i_head,
    input  logic               i_empty,
    output logic               o_pop,
    input  logic [15:0]        i_track,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output odo_pkg::t_out      o_out_data
);

    odo_pkg::t_state    r_state;
    odo_pkg::t_state    n_state;
    odo_pkg::t_cmd      r_cmd;
    odo_pkg::t_div_req  div_req;
    odo_pkg::t_cor_req  cor_req;
    logic               div_busy;
    logic [odo_pkg::DIV_BITS-1:0] div_quo;
    logic               cor_busy;
    logic signed [15:0] cor_sin;
    logic signed [15:0] cor_cos;

    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic [15:0]        r_h;
    logic [15:0]        r_h1;
    logic signed [15:0] r_s0;
    logic signed [15:0] r_c0;
    logic signed [15:0] r_s1;
    logic signed [15:0] r_c1;
    logic [47:0]        r_numq;
    logic [32:0]        r_numr;
    logic [47:0]        r_q48;
    logic [23:0]        r_hk;
    logic [47:0]        r_lk;
    logic signed [47:0] r_r48;
    logic [38:0]        r_dist;
    logic signed [41:0] r_plx;
    logic signed [40:0] r_phx;
    logic signed [41:0] r_ply;
    logic signed [40:0] r_phy;
    logic signed [40:0] r_plc;
    logic signed [30:0] r_phc;
    logic signed [40:0] r_pls;
    logic signed [30:0] r_phs;
    odo_pkg::t_out      r_out;
    logic               r_out_valid;

    logic signed [16:0] dd;
    logic signed [16:0] ss;
    logic [15:0]        absd;
    logic [16:0]        abss;
    logic [47:0]        numq_w;
    logic [32:0]        numr_w;
    logic [47:0]        quo48;
    logic [47:0]        q48_w;
    logic [47:0]        r48_w;
    logic [53:0]        hk_full;
    logic [53:0]        lk_full;
    logic [47:0]        p48;
    logic [15:0]        h1_w;
    logic signed [48:0] dist_w;
    logic signed [16:0] ds;
    logic signed [16:0] dc;
    logic signed [23:0] rh;
    logic signed [24:0] rl;
    logic signed [41:0] plx_w;
    logic signed [40:0] phx_w;
    logic signed [41:0] ply_w;
    logic signed [40:0] phy_w;
    logic signed [24:0] dlo;
    logic signed [14:0] dhi;
    logic signed [40:0] plc_w;
    logic signed [30:0] phc_w;
    logic signed [40:0] pls_w;
    logic signed [30:0] phs_w;
    logic [46:0]        sumx47;
    logic [46:0]        sumy47;
    logic [38:0]        sumx39;
    logic [38:0]        sumy39;
    logic               out_load;

    assign dd      = r_cmd.vr - r_cmd.vl;
    assign ss      = r_cmd.vr + r_cmd.vl;
    assign absd    = dd[16] ? 16'(-dd) : dd[15:0];
    assign abss    = ss[16] ? (~ss + 17'd1) : ss;
    assign numq_w  = absd * r_cmd.dt;
    assign numr_w  = i_track * abss;
    assign quo48   = div_quo[47:0];
    assign q48_w   = dd[16] ? (~quo48 + 48'd1) : quo48;
    assign r48_w   = (ss[16] ^ dd[16]) ? (~quo48 + 48'd1) : quo48;
    assign hk_full = r_q48[47:24] * odo_pkg::INV_TWO_PI;
    assign lk_full = r_q48[23:0] * odo_pkg::INV_TWO_PI;
    assign p48     = {r_hk, 24'd0} + r_lk;
    assign h1_w    = r_h + p48[47:32];
    assign dist_w  = r_cmd.vl * $signed({1'b0, r_cmd.dt});
    assign ds      = r_s1 - r_s0;
    assign dc      = r_c0 - r_c1;
    assign rh      = r_r48[47:24];
    assign rl      = $signed({1'b0, r_r48[23:0]});
    assign plx_w   = rl * ds;
    assign phx_w   = rh * ds;
    assign ply_w   = rl * dc;
    assign phy_w   = rh * dc;
    assign dlo     = $signed({1'b0, r_dist[23:0]});
    assign dhi     = $signed(r_dist[38:24]);
    assign plc_w   = dlo * r_c0;
    assign phc_w   = dhi * r_c0;
    assign pls_w   = dlo * r_s0;
    assign phs_w   = dhi * r_s0;
    assign sumx47  = 47'(r_plx) + {r_phx[22:0], 24'd0};
    assign sumy47  = 47'(r_ply) + {r_phy[22:0], 24'd0};
    assign sumx39  = 39'(r_plc) + {r_phc[14:0], 24'd0};
    assign sumy39  = 39'(r_pls) + {r_phs[14:0], 24'd0};
    assign out_load = (r_state == odo_pkg::S_DONE) && (!r_out_valid || !i_out_stall);

    odo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    odo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cor_req),
        .o_busy  (cor_busy),
        .o_sin   (cor_sin),
        .o_cos   (cor_cos)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            odo_pkg::S_IDLE: begin
                if (!i_empty) begin
                    unique case (i_head.kind)
                        odo_pkg::KIND_STRAIGHT: n_state = odo_pkg::S_SMUL;
                        odo_pkg::KIND_TURN:     n_state = odo_pkg::S_TNUM;
                        default:                n_state = odo_pkg::S_DONE;
                    endcase
                end
            end
            odo_pkg::S_TNUM:  n_state = odo_pkg::S_QGO;
            odo_pkg::S_QGO:   n_state = odo_pkg::S_QWAIT;
            odo_pkg::S_QWAIT: begin
                if (!div_busy && !cor_busy) begin
                    n_state = odo_pkg::S_DH1;
                end
            end
            odo_pkg::S_DH1:   n_state = odo_pkg::S_DH2;
            odo_pkg::S_DH2:   n_state = odo_pkg::S_RWAIT;
            odo_pkg::S_RWAIT: begin
                if (!div_busy && !cor_busy) begin
                    n_state = odo_pkg::S_TMUL;
                end
            end
            odo_pkg::S_TMUL:  n_state = odo_pkg::S_TSUM;
            odo_pkg::S_TSUM:  n_state = odo_pkg::S_DONE;
            odo_pkg::S_SMUL:  n_state = odo_pkg::S_SWAIT;
            odo_pkg::S_SWAIT: begin
                if (!cor_busy) begin
                    n_state = odo_pkg::S_SPROD;
                end
            end
            odo_pkg::S_SPROD: n_state = odo_pkg::S_SSUM;
            odo_pkg::S_SSUM:  n_state = odo_pkg::S_DONE;
            odo_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = odo_pkg::S_IDLE;
                end
            end
            default:          n_state = odo_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_pop            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {8'd0, r_numr, 15'd0};
        div_req.divisor  = absd;
        cor_req.start    = 1'b0;
        cor_req.angle    = h1_w;
        unique case (r_state)
            odo_pkg::S_IDLE: begin
                o_pop         = !i_empty;
                cor_req.start = !i_empty && (i_head.kind != odo_pkg::KIND_HOLD);
                cor_req.angle = r_h;
            end
            odo_pkg::S_QGO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {r_numq, 8'd0};
                div_req.divisor  = i_track;
            end
            odo_pkg::S_DH2: begin
                div_req.start = 1'b1;
                cor_req.start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= odo_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            odo_pkg::S_IDLE: begin
                if (!i_empty) begin
                    r_cmd <= i_head;
                end
            end
            odo_pkg::S_TNUM: begin
                r_numq <= numq_w;
                r_numr <= numr_w;
            end
            odo_pkg::S_QWAIT: begin
                r_q48 <= q48_w;
                r_s0  <= cor_sin;
                r_c0  <= cor_cos;
            end
            odo_pkg::S_DH1: begin
                r_hk <= hk_full[23:0];
                r_lk <= lk_full[47:0];
            end
            odo_pkg::S_DH2: begin
                r_h1 <= h1_w;
            end
            odo_pkg::S_RWAIT: begin
                r_r48 <= r48_w;
                r_s1  <= cor_sin;
                r_c1  <= cor_cos;
            end
            odo_pkg::S_TMUL: begin
                r_plx <= plx_w;
                r_phx <= phx_w;
                r_ply <= ply_w;
                r_phy <= phy_w;
            end
            odo_pkg::S_SMUL: begin
                r_dist <= dist_w[38:0];
            end
            odo_pkg::S_SWAIT: begin
                r_s0 <= cor_sin;
                r_c0 <= cor_cos;
            end
            odo_pkg::S_SPROD: begin
                r_plc <= plc_w;
                r_phc <= phc_w;
                r_pls <= pls_w;
                r_phs <= phs_w;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= 32'sd0;
            r_y <= 32'sd0;
            r_h <= 16'd0;
        end else if (r_state == odo_pkg::S_TSUM) begin
            r_x <= r_x + $signed(sumx47[46:15]);
            r_y <= r_y + $signed(sumy47[46:15]);
            r_h <= r_h1;
        end else if (r_state == odo_pkg::S_SSUM) begin
            r_x <= r_x + $signed(sumx39[38:7]);
            r_y <= r_y + $signed(sumy39[38:7]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.x_pos        <= r_x;
            r_out.y_pos        <= r_y;
            r_out.heading      <= r_h;
            r_out.pose_updated <= (r_cmd.kind != odo_pkg::KIND_HOLD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ODO_ASSERT_IMP(a_div_start_free, div_req.start, !div_busy, "divider restarted while busy")
    `ODO_ASSERT_IMP(a_cor_start_free, cor_req.start, !cor_busy, "CORDIC restarted while busy")
    `ODO_ASSERT_NEXT(a_done_loads, (r_state == odo_pkg::S_DONE) && !r_out_valid, r_out_valid, "finished word not loaded")
    `ODO_ASSERT_IMP(a_pop_idle, o_pop, r_state == odo_pkg::S_IDLE, "command taken while busy")

endmodule

// ===== hw/rtl/differential_drive_odometry_core.sv =====
// Differential drive odometry core: front end, command queue and back end.
// A word that leaves the pose alone goes straight to the done state, a straight move waits on one CORDIC run,
// and a turn waits on two divider runs and two CORDIC runs.
// One word is in the back end at a time, so the back end takes no new word until the last one is loaded
// into the output register; the queue takes further words meanwhile.
// Synchronous active-low reset clears the pose to zero and restores register defaults.
module differential_drive_odometry_core #(
    parameter int QUEUE_DEPTH = odo_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  odo_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output odo_pkg::t_out  o_out_data,
    input  logic           i_cfg_we,
    input  logic [0:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_data
);

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    logic [15:0]   track;
    odo_pkg::t_cmd cmd;
    odo_pkg::t_cmd head;

    odo_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (cmd),
        .o_track    (track)
    );

    odo_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    odo_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .i_track     (track),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== verif/differential_drive_odometry_checker.sv =====
// Checker for the differential drive odometry core: watches both channels,
// predicts each pose word and compares it field by field. Depends on odo_pkg.
module differential_drive_odometry_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  odo_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  odo_pkg::t_out i_out_data,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_updates,
    output int            o_turns
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ATAN_TAB [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
                                     10, 5, 3, 1};

    logic [15:0]   track_w;
    logic [15:0]   interval;
    logic [31:0]   px;
    logic [31:0]   py;
    logic [15:0]   ph;
    logic [31:0]   last_ms;
    odo_pkg::t_out pose_q[$];

    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic void cordic_sin_cos(logic [15:0] ang, output int s, output int c);
        logic [15:0] a;
        logic        flip;
        int          x;
        int          y;
        int          z;
        int          xs;
        int          ys;
        a = ang;
        flip = a[15] ^ a[14];
        if (flip) a[15] = ~a[15];
        x = 19898;
        y = 0;
        z = int'($signed(a));
        for (int i = 0; i < 14; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ATAN_TAB[i];
            end else begin
                x += ys; y -= xs; z += ATAN_TAB[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        s = (y > 32767) ? 32767 : (y < -32767) ? -32767 : y;
        c = (x > 32767) ? 32767 : (x < -32767) ? -32767 : x;
    endfunction

    function automatic odo_pkg::t_out advance_pose(odo_pkg::t_in w);
        odo_pkg::t_out r;
        logic [31:0] dt;
        longint      vl;
        longint      vr;
        longint      travel;
        longint      dx;
        longint      dy;
        longint      lw;
        longint      rad;
        longint      q;
        logic [47:0] u48;
        logic [47:0] prod;
        logic [15:0] dh;
        logic [15:0] h1;
        int          s0;
        int          c0;
        int          s1;
        int          c1;
        dt = w.now_ms - last_ms;
        vl = longint'(w.left_speed);
        vr = longint'(w.right_speed);
        r.pose_updated = (dt >= {16'd0, interval});
        if (r.pose_updated) begin
            cordic_sin_cos(ph, s0, c0);
            if (vl == vr) begin
                travel = vl * longint'({32'd0, dt});
                dx = floor_shr(travel * c0, 7);
                dy = floor_shr(travel * s0, 7);
            end else begin
                lw = (track_w == 0) ? 1 : longint'({48'd0, track_w});
                rad = (lw * (vr + vl) * 32768) / (vr - vl);
                q = ((vr - vl) * longint'({32'd0, dt}) * 256) / lw;
                u48 = q[47:0];
                prod = 48'(({24'd0, u48[47:24]} * 64'd683565276) << 24)
                     + 48'({40'd0, u48[23:0]} * 64'd683565276);
                dh = prod[47:32];
                h1 = ph + dh;
                cordic_sin_cos(h1, s1, c1);
                dx = floor_shr(rad * (s1 - s0), 15);
                dy = floor_shr(rad * (c0 - c1), 15);
                ph = h1;
                o_turns++;
            end
            px = px + dx[31:0];
            py = py + dy[31:0];
            last_ms = w.now_ms;
            o_updates++;
        end
        r.x_pos = px;
        r.y_pos = py;
        r.heading = ph;
        return r;
    endfunction

    always @(posedge i_clk) begin
        odo_pkg::t_out e;
        if (!i_rst_n) begin
            track_w <= odo_pkg::TRACK_WIDTH_RESET;
            interval <= odo_pkg::INTERVAL_RESET;
            px = 0;
            py = 0;
            ph = 0;
            last_ms = 0;
            pose_q.delete();
            o_fail_count <= 0;
            o_updates = 0;
            o_turns = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == odo_pkg::CFG_TRACK_WIDTH) track_w <= i_cfg_data;
                else interval <= i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) pose_q.push_back(advance_pose(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (pose_q.size() == 0) begin
                    $error("pose word with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = pose_q.pop_front();
                    if (e != i_out_data) o_fail_count <= o_fail_count + 1;
                    if (e.x_pos != i_out_data.x_pos)
                        $error("x_pos exp %0d got %0d", e.x_pos, i_out_data.x_pos);
                    if (e.y_pos != i_out_data.y_pos)
                        $error("y_pos exp %0d got %0d", e.y_pos, i_out_data.y_pos);
                    if (e.heading != i_out_data.heading)
                        $error("heading exp %0d got %0d", e.heading, i_out_data.heading);
                    if (e.pose_updated != i_out_data.pose_updated)
                        $error("pose_updated exp %0d got %0d", e.pose_updated,
                               i_out_data.pose_updated);
                end
            end
        end
        o_pending = pose_q.size();
    end
endmodule

// ===== verif/differential_drive_odometry_core_tb.sv =====
// Testbench top for the differential drive odometry core: drives words and
// register writes with random gaps and stalls. Depends on odo_pkg, the core and the checker.
module differential_drive_odometry_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    odo_pkg::t_in  in_data;
    logic          out_valid;
    logic          out_stall;
    odo_pkg::t_out out_data;
    logic          cfg_we;
    logic [0:0]    cfg_idx;
    logic [15:0]   cfg_data;
    int            fail_count;
    int            pending;
    int            updates;
    int            turns;
    int            send_idle_pct;
    int            stall_pct;
    bit            hold_off;
    logic [31:0]   clock_ms;

    differential_drive_odometry_core uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_in_data(in_data), .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_out_data(out_data), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data)
    );

    differential_drive_odometry_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_in_data(in_data), .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_out_data(out_data), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .o_fail_count(fail_count), .o_pending(pending),
        .o_updates(updates), .o_turns(turns)
    );

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    always @(negedge clk) begin
        if (hold_off) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_word(logic [31:0] now, logic [15:0] vl, logic [15:0] vr);
        while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        in_valid = 1'b1;
        in_data = '{now_ms: now, left_speed: vl, right_speed: vr};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        while (pending != 0) @(negedge clk);
        repeat (80) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_speeds(output logic [15:0] vl, output logic [15:0] vr);
        case ($urandom_range(5))
            0: begin vl = 16'($urandom); vr = vl; end
            1: begin vl = 16'($urandom); vr = 16'($urandom); end
            2: begin vl = 16'($urandom_range(1024)); vr = 16'(vl + $urandom_range(64)); end
            default: begin
                vl = 16'($urandom_range(2048) - 1024);
                vr = 16'($urandom_range(2048) - 1024);
            end
        endcase
    endtask

    task automatic random_phase(int n, int idle, int stall);
        logic [15:0] vl;
        logic [15:0] vr;
        send_idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            random_speeds(vl, vr);
            case ($urandom_range(9))
                0: clock_ms = $urandom;
                1, 2: clock_ms += $urandom_range(20);
                default: clock_ms += $urandom_range(200);
            endcase
            send_word(clock_ms, vl, vr);
        end
    endtask

    initial begin
        logic [15:0] vl;
        logic [15:0] vr;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        out_stall = 0;
        cfg_we = 0;
        cfg_idx = odo_pkg::CFG_TRACK_WIDTH;
        cfg_data = 0;
        hold_off = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        clock_ms = 0;
        repeat (9) @(negedge clk);
        rst_n = 1;

        send_word(32'd10, 16'h0100, 16'h0100);
        send_word(32'd60, 16'h0100, 16'h0100);
        send_word(32'd200, 16'h7FFF, 16'h7FFF);
        send_word(32'd300, 16'h8000, 16'h8000);
        send_word(32'd400, 16'h8000, 16'h7FFF);
        send_word(32'd500, 16'h7FFF, 16'h8000);
        send_word(32'd600, 16'h0000, 16'h0200);
        send_word(32'hFFFF_FFFF, 16'hFFFF, 16'h0001);
        send_word(32'd40, 16'h0100, 16'h0180);
        send_word(32'h8000_0000, 16'h0000, 16'h0000);
        write_reg(odo_pkg::CFG_TRACK_WIDTH, 16'd0);
        write_reg(odo_pkg::CFG_INTERVAL, 16'd0);
        send_word(32'h8000_0000, 16'h0010, 16'h0300);
        send_word(32'h8000_0001, 16'h0300, 16'h0010);
        write_reg(odo_pkg::CFG_TRACK_WIDTH, 16'hFFFF);
        write_reg(odo_pkg::CFG_INTERVAL, 16'hFFFF);
        send_word(32'h8001_0000, 16'h0010, 16'h0300);
        send_word(32'h8001_FFFE, 16'h0010, 16'h0300);
        send_word(32'h8002_0000, 16'h5555, 16'hAAAA);
        clock_ms = 32'h8002_0000;

        write_reg(odo_pkg::CFG_TRACK_WIDTH, 16'd141);
        write_reg(odo_pkg::CFG_INTERVAL, 16'd50);
        random_phase(400, 0, 0);
        write_reg(odo_pkg::CFG_INTERVAL, 16'd1);
        write_reg(odo_pkg::CFG_TRACK_WIDTH, 16'd1);
        random_phase(300, 81, 0);
        write_reg(odo_pkg::CFG_TRACK_WIDTH, 16'($urandom_range(65535)));
        write_reg(odo_pkg::CFG_INTERVAL, 16'($urandom_range(100)));
        random_phase(300, 0, 81);
        write_reg(odo_pkg::CFG_TRACK_WIDTH, 16'd300);
        write_reg(odo_pkg::CFG_INTERVAL, 16'd0);
        random_phase(300, 33, 33);

        hold_off = 1;
        fork
            begin
                repeat (600) @(negedge clk);
                hold_off = 0;
            end
            random_phase(300, 0, 0);
        join

        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        $display("Covered about 1600 words: %0d pose updates, %0d of them turns,", updates,
                 turns);
        $display("over six register settings and varied gaps and stalls.");
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
